FILE: hw/rtl/point_range_histogram_defines.svh
// Assertion macros used by the point range histogram top level.
`ifndef POINT_RANGE_HISTOGRAM_DEFINES_SVH
`define POINT_RANGE_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define PRH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define PRH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/prh_pkg.sv
// Package: constants and inter-module types of the point range histogram.
`timescale 1ns / 1ps
package prh_pkg;

    localparam int COORD_W    = 18;
    localparam int NUM_BINS   = 20;
    localparam int MAX_POINTS = 1048576;

    localparam int BIN_W      = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int BIN_IDX_W  = 5;
    localparam int CNT_W      = 21;
    localparam int WIDTH_W    = 16;
    localparam logic [WIDTH_W-1:0] WIDTH_RST = 16'd1000;
    localparam int SUM_W      = 39;
    localparam int MEAN_W     = 18;
    localparam int LIM_W      = WIDTH_W + BIN_W + 1;

    localparam int ROOT_W     = COORD_W;
    localparam int RAD_W      = 2 * COORD_W;

    localparam int DIV_QW     = (MEAN_W + 1 > BIN_W) ? MEAN_W + 1 : BIN_W;
    localparam int DIV_CW     = $clog2(DIV_QW + 1);

    localparam logic KIND_BIN = 1'b0;
    localparam logic KIND_SUM = 1'b1;

    typedef struct packed {
        logic                      start;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_rng_req;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] range;
    } t_rng_rsp;

    typedef struct packed {
        logic              start;
        logic [DIV_CW-1:0] steps;
        logic [SUM_W-1:0]  dividend;
        logic [SUM_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_QW-1:0] quo;
    } t_div_rsp;

endpackage

FILE: hw/rtl/prh_range.sv
// Range unit: sum of squares on one shared multiplier, then a bit-per-cycle square root.
`timescale 1ns / 1ps
module prh_range (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  prh_pkg::t_rng_req i_req,
    output prh_pkg::t_rng_rsp o_rsp
);

    localparam int RC_W  = $clog2(prh_pkg::ROOT_W);
    localparam int REM_W = prh_pkg::ROOT_W + 2;

    typedef enum logic [2:0] {
        R_IDLE = 3'b001,
        R_SQ   = 3'b010,
        R_ROOT = 3'b100
    } t_rng_state;

    t_rng_state                     r_state;
    logic [prh_pkg::COORD_W-1:0]    r_mag [3];
    logic [RC_W-1:0]                r_cnt;
    logic [prh_pkg::RAD_W-1:0]      r_prod;
    logic [prh_pkg::RAD_W-1:0]      r_acc;
    logic [prh_pkg::RAD_W-1:0]      r_rad;
    logic [REM_W-1:0]               r_rem;
    logic [prh_pkg::ROOT_W-1:0]     r_root;
    logic                           r_done;

    logic [prh_pkg::COORD_W-1:0]    mag_x;
    logic [prh_pkg::COORD_W-1:0]    mag_y;
    logic [prh_pkg::COORD_W-1:0]    mag_z;
    logic [REM_W-1:0]               rem_sh;
    logic [REM_W-1:0]               trial;

    assign mag_x = i_req.x[prh_pkg::COORD_W-1] ? prh_pkg::COORD_W'(-i_req.x)
                                                : prh_pkg::COORD_W'(i_req.x);
    assign mag_y = i_req.y[prh_pkg::COORD_W-1] ? prh_pkg::COORD_W'(-i_req.y)
                                                : prh_pkg::COORD_W'(i_req.y);
    assign mag_z = i_req.z[prh_pkg::COORD_W-1] ? prh_pkg::COORD_W'(-i_req.z)
                                                : prh_pkg::COORD_W'(i_req.z);

    assign rem_sh = {r_rem[REM_W-3:0], r_rad[prh_pkg::RAD_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                R_IDLE: begin
                    if (i_req.start) begin
                        r_state <= R_SQ;
                    end
                end
                R_SQ: begin
                    if (r_cnt == RC_W'(3)) begin
                        r_state <= R_ROOT;
                    end
                end
                R_ROOT: begin
                    if (r_cnt == RC_W'(prh_pkg::ROOT_W - 1)) begin
                        r_state <= R_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= R_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            R_IDLE: begin
                r_mag[0] <= mag_x;
                r_mag[1] <= mag_y;
                r_mag[2] <= mag_z;
                r_cnt    <= '0;
                r_acc    <= '0;
            end
            R_SQ: begin
                r_prod   <= prh_pkg::RAD_W'(r_mag[0]) * prh_pkg::RAD_W'(r_mag[0]);
                r_mag[0] <= r_mag[1];
                r_mag[1] <= r_mag[2];
                if (r_cnt != '0) begin
                    r_acc <= r_acc + r_prod;
                end
                if (r_cnt == RC_W'(3)) begin
                    r_rad  <= r_acc + r_prod;
                    r_rem  <= '0;
                    r_root <= '0;
                    r_cnt  <= '0;
                end else begin
                    r_cnt <= r_cnt + RC_W'(1);
                end
            end
            R_ROOT: begin
                r_rad <= {r_rad[prh_pkg::RAD_W-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[prh_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[prh_pkg::ROOT_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + RC_W'(1);
            end
            default: r_cnt <= '0;
        endcase
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.range = r_root;

endmodule

FILE: hw/rtl/prh_div.sv
// Restoring divider, one quotient bit per cycle, shared by bin index and mean.
`timescale 1ns / 1ps
module prh_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  prh_pkg::t_div_req i_req,
    output prh_pkg::t_div_rsp o_rsp
);

    typedef enum logic [1:0] {
        D_IDLE = 2'b01,
        D_RUN  = 2'b10
    } t_div_state;

    t_div_state                   r_state;
    logic [prh_pkg::SUM_W-1:0]    r_rem;
    logic [prh_pkg::SUM_W-1:0]    r_dsr;
    logic [prh_pkg::DIV_QW-1:0]   r_quo;
    logic [prh_pkg::DIV_CW-1:0]   r_left;
    logic                         r_done;

    logic                         ge;

    assign ge = (r_rem >= r_dsr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_req.start) begin
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    if (r_left == prh_pkg::DIV_CW'(1)) begin
                        r_state <= D_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == D_IDLE) begin
            r_rem  <= i_req.dividend;
            r_dsr  <= i_req.divisor;
            r_quo  <= '0;
            r_left <= i_req.steps;
        end else begin
            if (ge) begin
                r_rem <= r_rem - r_dsr;
            end
            r_quo  <= {r_quo[prh_pkg::DIV_QW-2:0], ge};
            r_dsr  <= {1'b0, r_dsr[prh_pkg::SUM_W-1:1]};
            r_left <= r_left - prh_pkg::DIV_CW'(1);
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

FILE: hw/rtl/point_range_histogram.sv
// Top level: point sequencer, bin memory, cloud totals and result register.
//
//  channel  | handshake            | beat
//  ---------+----------------------+---------------------------------------------
//  points   | i_valid / o_ready    | i_coord_x/y/z, i_last_point
//  results  | o_valid / i_ready    | o_item_kind, o_bin_index, o_bin_total,
//           |                      | o_point_total, o_mean_range_cm, o_last_result
//  config   | i_cfg_wr_en          | i_cfg_wr_data (bin width, cm)
//
// One point at a time: the 18-step square root, then, when the range lands in a bin,
// the 5-step bin divide and the bin read-modify-write. A last point adds a bin read
// and an output load per bin, a 19-step mean divide and the summary beat.
// o_ready is low while a point or the result burst is in progress; a stalled result
// holds the burst. Reset is synchronous, active low; bins clear at once via valid bits.
`timescale 1ns / 1ps
`include "point_range_histogram_defines.svh"
module point_range_histogram (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [prh_pkg::WIDTH_W-1:0]          i_cfg_wr_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [prh_pkg::COORD_W-1:0]   i_coord_x,
    input  logic signed [prh_pkg::COORD_W-1:0]   i_coord_y,
    input  logic signed [prh_pkg::COORD_W-1:0]   i_coord_z,
    input  logic                                 i_last_point,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_item_kind,
    output logic [prh_pkg::BIN_IDX_W-1:0]        o_bin_index,
    output logic [prh_pkg::CNT_W-1:0]            o_bin_total,
    output logic [prh_pkg::CNT_W-1:0]            o_point_total,
    output logic [prh_pkg::MEAN_W-1:0]           o_mean_range_cm,
    output logic                                 o_last_result
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_RANGE   = 8'b0000_0010,
        S_DIV     = 8'b0000_0100,
        S_UPD     = 8'b0000_1000,
        S_EMIT_RD = 8'b0001_0000,
        S_EMIT_LD = 8'b0010_0000,
        S_MEAN    = 8'b0100_0000,
        S_SUM_LD  = 8'b1000_0000
    } t_seq_state;

    t_seq_state                      r_state, n_state;
    logic [prh_pkg::WIDTH_W-1:0]     r_bin_width;
    logic                            r_last;
    logic [prh_pkg::CNT_W-1:0]       r_point_cnt, n_point_cnt;
    logic [prh_pkg::SUM_W-1:0]       r_sum, n_sum;
    logic [prh_pkg::BIN_W-1:0]       r_bin, n_bin;
    logic [prh_pkg::BIN_W-1:0]       r_idx, n_idx;
    logic [prh_pkg::MEAN_W-1:0]      r_mean, n_mean;
    logic [prh_pkg::NUM_BINS-1:0]    r_bin_vld;

    logic [prh_pkg::CNT_W-1:0]       r_mem [prh_pkg::NUM_BINS];
    logic [prh_pkg::CNT_W-1:0]       r_rd_data;
    logic                            r_rd_vld;

    logic                            r_o_valid;
    logic                            r_o_kind;
    logic [prh_pkg::BIN_IDX_W-1:0]   r_o_idx;
    logic [prh_pkg::CNT_W-1:0]       r_o_bin_total;
    logic [prh_pkg::CNT_W-1:0]       r_o_pt_total;
    logic [prh_pkg::MEAN_W-1:0]      r_o_mean;
    logic                            r_o_last;

    prh_pkg::t_rng_req               rng_req;
    prh_pkg::t_rng_rsp               rng_rsp;
    prh_pkg::t_div_req               div_req;
    prh_pkg::t_div_rsp               div_rsp;

    logic                            in_acc;
    logic                            out_free;
    logic                            out_ld_bin;
    logic                            out_ld_sum;
    logic                            mem_rd_en;
    logic [prh_pkg::BIN_W-1:0]       mem_rd_addr;
    logic                            mem_we;
    logic [prh_pkg::CNT_W-1:0]       bin_cur;
    logic [prh_pkg::WIDTH_W-1:0]     width_eff;
    logic [prh_pkg::LIM_W-1:0]       range_lim;
    logic [prh_pkg::SUM_W:0]         sum_ext;
    logic [prh_pkg::CNT_W-1:0]       bin_rd_total;

    assign o_ready   = (r_state == S_IDLE);
    assign in_acc    = i_valid && o_ready;
    assign out_free  = !r_o_valid || i_ready;
    assign width_eff = (r_bin_width == '0) ? prh_pkg::WIDTH_W'(1) : r_bin_width;
    assign range_lim = prh_pkg::LIM_W'(width_eff) * prh_pkg::LIM_W'(prh_pkg::NUM_BINS);
    assign sum_ext   = {1'b0, r_sum} + (prh_pkg::SUM_W + 1)'(rng_rsp.range);
    assign bin_rd_total = r_rd_vld ? r_rd_data : '0;
    assign bin_cur   = bin_rd_total;

    assign rng_req.start = in_acc;
    assign rng_req.x     = i_coord_x;
    assign rng_req.y     = i_coord_y;
    assign rng_req.z     = i_coord_z;

    always_comb begin
        n_state     = r_state;
        n_point_cnt = r_point_cnt;
        n_sum       = r_sum;
        n_bin       = r_bin;
        n_idx       = r_idx;
        n_mean      = r_mean;
        div_req     = '0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_idx;
        mem_we      = 1'b0;
        out_ld_bin  = 1'b0;
        out_ld_sum  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_RANGE;
                end
            end
            S_RANGE: begin
                if (rng_rsp.done) begin
                    if (r_point_cnt < prh_pkg::CNT_W'(prh_pkg::MAX_POINTS)) begin
                        n_point_cnt = r_point_cnt + prh_pkg::CNT_W'(1);
                        n_sum = sum_ext[prh_pkg::SUM_W] ? '1 : sum_ext[prh_pkg::SUM_W-1:0];
                    end
                    if (prh_pkg::LIM_W'(rng_rsp.range) < range_lim) begin
                        div_req.start    = 1'b1;
                        div_req.steps    = prh_pkg::DIV_CW'(prh_pkg::BIN_W);
                        div_req.dividend = prh_pkg::SUM_W'(rng_rsp.range);
                        div_req.divisor  = prh_pkg::SUM_W'(width_eff) << (prh_pkg::BIN_W - 1);
                        n_state = S_DIV;
                    end else if (r_last) begin
                        n_state = S_EMIT_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = div_rsp.quo[prh_pkg::BIN_W-1:0];
                    n_bin       = div_rsp.quo[prh_pkg::BIN_W-1:0];
                    n_state     = S_UPD;
                end
            end
            S_UPD: begin
                mem_we  = (bin_cur < prh_pkg::CNT_W'(prh_pkg::MAX_POINTS));
                n_state = r_last ? S_EMIT_RD : S_IDLE;
            end
            S_EMIT_RD: begin
                mem_rd_en = 1'b1;
                n_state   = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (out_free) begin
                    out_ld_bin = 1'b1;
                    if (r_idx == prh_pkg::BIN_W'(prh_pkg::NUM_BINS - 1)) begin
                        div_req.start    = 1'b1;
                        div_req.steps    = prh_pkg::DIV_CW'(prh_pkg::MEAN_W + 1);
                        div_req.dividend = r_sum;
                        div_req.divisor  = prh_pkg::SUM_W'(r_point_cnt) << prh_pkg::MEAN_W;
                        n_idx   = '0;
                        n_state = S_MEAN;
                    end else begin
                        n_idx   = r_idx + prh_pkg::BIN_W'(1);
                        n_state = S_EMIT_RD;
                    end
                end
            end
            S_MEAN: begin
                if (div_rsp.done) begin
                    // quotient bit above the mean width flags overflow
                    n_mean  = div_rsp.quo[prh_pkg::MEAN_W] ? '1
                                                           : div_rsp.quo[prh_pkg::MEAN_W-1:0];
                    n_state = S_SUM_LD;
                end
            end
            S_SUM_LD: begin
                if (out_free) begin
                    out_ld_sum  = 1'b1;
                    n_point_cnt = '0;
                    n_sum       = '0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bin_width <= prh_pkg::WIDTH_RST;
            r_point_cnt <= '0;
            r_sum       <= '0;
            r_bin_vld   <= '0;
            r_idx       <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_point_cnt <= n_point_cnt;
            r_sum       <= n_sum;
            r_idx       <= n_idx;
            if (i_cfg_wr_en) begin
                r_bin_width <= i_cfg_wr_data;
            end
            if (out_ld_sum) begin
                r_bin_vld <= '0;
            end else if (mem_we) begin
                r_bin_vld[r_bin] <= 1'b1;
            end
            if (out_ld_bin || out_ld_sum) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_mean <= n_mean;
        if (in_acc) begin
            r_last <= i_last_point;
        end
        if (out_ld_bin) begin
            r_o_kind      <= prh_pkg::KIND_BIN;
            r_o_idx       <= prh_pkg::BIN_IDX_W'(r_idx);
            r_o_bin_total <= bin_rd_total;
            r_o_pt_total  <= '0;
            r_o_mean      <= '0;
            r_o_last      <= 1'b0;
        end else if (out_ld_sum) begin
            r_o_kind      <= prh_pkg::KIND_SUM;
            r_o_idx       <= '0;
            r_o_bin_total <= '0;
            r_o_pt_total  <= r_point_cnt;
            r_o_mean      <= r_mean;
            r_o_last      <= 1'b1;
        end
    end

    // bin memory: one read port, one write port, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_bin] <= bin_cur + prh_pkg::CNT_W'(1);
        end
        if (mem_rd_en) begin
            r_rd_data <= r_mem[mem_rd_addr];
            r_rd_vld  <= r_bin_vld[mem_rd_addr];
        end
    end

    prh_range u_range (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rng_req),
        .o_rsp   (rng_rsp)
    );

    prh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_valid         = r_o_valid;
    assign o_item_kind     = r_o_kind;
    assign o_bin_index     = r_o_idx;
    assign o_bin_total     = r_o_bin_total;
    assign o_point_total   = r_o_pt_total;
    assign o_mean_range_cm = r_o_mean;
    assign o_last_result   = r_o_last;

    `PRH_ASSERT_IMP(a_rng_done_state, rng_rsp.done, r_state == S_RANGE, "range result outside range wait")
    `PRH_ASSERT_IMP(a_div_done_state, div_rsp.done, (r_state == S_DIV) || (r_state == S_MEAN), "divider result with no divide pending")
    `PRH_ASSERT_NXT(a_cloud_cleared, out_ld_sum, (r_point_cnt == '0) && (r_sum == '0) && (r_bin_vld == '0), "cloud state not cleared after summary")
    `PRH_ASSERT_IMP(a_cnt_cap, 1'b1, r_point_cnt <= prh_pkg::CNT_W'(prh_pkg::MAX_POINTS), "point count above cap")

endmodule

FILE: test/testbench.sv
// Testbench for point_range_histogram: self-checking point clouds against a range/bin predictor.
`timescale 1ns / 1ps
module testbench;

    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 64;
    localparam int COORD_MAX    = (1 << (prh_pkg::COORD_W - 1)) - 1;
    localparam logic [63:0] SUM_CAP  = (64'd1 << prh_pkg::SUM_W) - 1;
    localparam logic [63:0] MEAN_CAP = (64'd1 << prh_pkg::MEAN_W) - 1;

    typedef struct packed {
        logic                          kind;
        logic [prh_pkg::BIN_IDX_W-1:0] idx;
        logic [prh_pkg::CNT_W-1:0]     bin_tot;
        logic [prh_pkg::CNT_W-1:0]     pt_tot;
        logic [prh_pkg::MEAN_W-1:0]    mean;
        logic                          last_beat;
    } t_histo_beat;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_cfg_wr_en;
    logic [prh_pkg::WIDTH_W-1:0]        i_cfg_wr_data;
    logic                               i_valid;
    logic                               o_ready;
    logic signed [prh_pkg::COORD_W-1:0] i_coord_x;
    logic signed [prh_pkg::COORD_W-1:0] i_coord_y;
    logic signed [prh_pkg::COORD_W-1:0] i_coord_z;
    logic                               i_last_point;
    logic                               o_valid;
    logic                               i_ready;
    logic                               o_item_kind;
    logic [prh_pkg::BIN_IDX_W-1:0]      o_bin_index;
    logic [prh_pkg::CNT_W-1:0]          o_bin_total;
    logic [prh_pkg::CNT_W-1:0]          o_point_total;
    logic [prh_pkg::MEAN_W-1:0]         o_mean_range_cm;
    logic                               o_last_result;

    // predictor state
    logic [prh_pkg::CNT_W-1:0]   bin_hits [prh_pkg::NUM_BINS];
    logic [63:0]                 cloud_sum;
    logic [63:0]                 cloud_points;
    logic [prh_pkg::WIDTH_W-1:0] bin_width;
    t_histo_beat                 expected_beats [$];
    t_histo_beat                 next_beat;

    int error_count;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int quiet_cycles;

    point_range_histogram i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_coord_x       (i_coord_x),
        .i_coord_y       (i_coord_y),
        .i_coord_z       (i_coord_z),
        .i_last_point    (i_last_point),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_item_kind     (o_item_kind),
        .o_bin_index     (o_bin_index),
        .o_bin_total     (o_bin_total),
        .o_point_total   (o_point_total),
        .o_mean_range_cm (o_mean_range_cm),
        .o_last_result   (o_last_result)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        int          b;
        root = 0;
        for (b = prh_pkg::ROOT_W; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
        end
        return root;
    endfunction

    function automatic logic [63:0] magnitude(input logic signed [prh_pkg::COORD_W-1:0] c);
        logic signed [63:0] wide;
        wide = c;
        return (wide < 0) ? -wide : wide;
    endfunction

    task automatic clear_cloud_model();
        int i;
        for (i = 0; i < prh_pkg::NUM_BINS; i++) bin_hits[i] = '0;
        cloud_sum    = 0;
        cloud_points = 0;
    endtask

    // Fold one point into the cloud; on the last point queue the bin beats and the summary.
    task automatic absorb_point(input logic signed [prh_pkg::COORD_W-1:0] cx, cy, cz,
                                input logic last);
        logic [63:0] ax, ay, az, rng, w, b, total, avg;
        t_histo_beat beat;
        int          i;
        ax  = magnitude(cx);
        ay  = magnitude(cy);
        az  = magnitude(cz);
        w   = (bin_width == 0) ? 64'd1 : 64'(bin_width);
        rng = floor_sqrt(ax * ax + ay * ay + az * az);
        if (cloud_points < prh_pkg::MAX_POINTS) begin
            cloud_points = cloud_points + 1;
            total        = cloud_sum + rng;
            cloud_sum    = (total > SUM_CAP) ? SUM_CAP : total;
        end
        if (rng < prh_pkg::NUM_BINS * w) begin
            b = rng / w;
            if (b < prh_pkg::NUM_BINS && bin_hits[b] < prh_pkg::MAX_POINTS)
                bin_hits[b] = bin_hits[b] + 1'b1;
        end
        if (last) begin
            for (i = 0; i < prh_pkg::NUM_BINS; i++) begin
                beat         = '0;
                beat.kind    = prh_pkg::KIND_BIN;
                beat.idx     = prh_pkg::BIN_IDX_W'(i);
                beat.bin_tot = bin_hits[i];
                expected_beats.push_back(beat);
            end
            avg            = (cloud_points != 0) ? cloud_sum / cloud_points : 0;
            beat           = '0;
            beat.kind      = prh_pkg::KIND_SUM;
            beat.pt_tot    = prh_pkg::CNT_W'(cloud_points);
            beat.mean      = prh_pkg::MEAN_W'((avg > MEAN_CAP) ? MEAN_CAP : avg);
            beat.last_beat = 1'b1;
            expected_beats.push_back(beat);
            clear_cloud_model();
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want, got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_beats.size() == 0) begin
                $error("result beat with nothing expected, bin_index %0d", o_bin_index);
                error_count++;
            end else begin
                next_beat = expected_beats.pop_front();
                check_field("item_kind", next_beat.kind, o_item_kind);
                check_field("bin_index", next_beat.idx, o_bin_index);
                check_field("bin_total", next_beat.bin_tot, o_bin_total);
                check_field("point_total", next_beat.pt_tot, o_point_total);
                check_field("mean_range_cm", next_beat.mean, o_mean_range_cm);
                check_field("last_result", next_beat.last_beat, o_last_result);
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    task automatic send_point(input logic signed [prh_pkg::COORD_W-1:0] cx, cy, cz,
                              input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_coord_x    <= cx;
        i_coord_y    <= cy;
        i_coord_z    <= cz;
        i_last_point <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        absorb_point(cx, cy, cz, last);
        @(negedge i_clk);
    endtask

    task automatic set_bin_width(input logic [prh_pkg::WIDTH_W-1:0] w);
        i_valid <= 1'b0;
        while (expected_beats.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= w;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        bin_width = w;
    endtask

    // Mostly spans that land in the bins, some full-scale coordinates.
    function automatic logic signed [prh_pkg::COORD_W-1:0] pick_coord(input int span);
        int v;
        if (span >= COORD_MAX || $urandom_range(5) == 0) return prh_pkg::COORD_W'($urandom);
        v = $urandom_range(0, 2 * span);
        return prh_pkg::COORD_W'(v - span);
    endfunction

    task automatic send_cloud(input int npts);
        int span;
        int k;
        span = ((bin_width == 0) ? 1 : int'(bin_width)) * prh_pkg::NUM_BINS * 3 / 5;
        if (span > COORD_MAX) span = COORD_MAX;
        for (k = 0; k < npts; k++)
            send_point(pick_coord(span), pick_coord(span), pick_coord(span), k == npts - 1);
    endtask

    task automatic test_directed_extremes();
        send_point(0, 0, 0, 1'b0);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        send_point(-COORD_MAX - 1, -COORD_MAX - 1, -COORD_MAX - 1, 1'b0);
        send_point(-1, -1, -1, 1'b0);
        send_point(19999, 0, 0, 1'b0);
        send_point(20000, 0, 0, 1'b0);
        send_point(0, -999, 0, 1'b0);
        send_point(0, 0, 1000, 1'b0);
        send_point(-COORD_MAX - 1, COORD_MAX, 0, 1'b1);
        // one-point cloud
        send_point(3, 4, -12, 1'b1);
    endtask

    task automatic test_zero_bin_width();
        set_bin_width(16'd0);
        send_point(0, 0, 0, 1'b0);
        send_point(0, 19, 0, 1'b0);
        send_point(0, 0, 20, 1'b0);
        send_point(-12, -16, 0, 1'b0);
        send_point(11, -2, -10, 1'b1);
    endtask

    task automatic test_widest_bins();
        set_bin_width(16'hffff);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        send_point(65534, 0, 0, 1'b0);
        send_point(0, 65535, 0, 1'b1);
    endtask

    task automatic test_random_clouds();
        int                          phase;
        int                          sent;
        int                          n;
        logic [prh_pkg::WIDTH_W-1:0] w;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;  recv_stall_pct = 0;  w = 16'd1;
                end
                1: begin
                    send_idle_pct = 77; recv_stall_pct = 0;
                    w = prh_pkg::WIDTH_W'($urandom_range(2, 4000));
                end
                2: begin
                    send_idle_pct = 0;  recv_stall_pct = 77; w = prh_pkg::WIDTH_RST;
                end
                default: begin
                    send_idle_pct = 23; recv_stall_pct = 23;
                    w = prh_pkg::WIDTH_W'($urandom_range(1, 65535));
                end
            endcase
            set_bin_width(w);
            sent = 0;
            while (sent < 45) begin
                n = $urandom_range(1, 12);
                send_cloud(n);
                sent += n;
            end
        end
    endtask

    // Results held off while points keep coming, so the block backs up its input.
    task automatic test_result_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_bin_width(16'd250);
        @(posedge i_clk);
        hold_cycles = 500;
        @(negedge i_clk);
        send_cloud(4);
        send_cloud(4);
        send_cloud(3);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = prh_pkg::WIDTH_RST;
        i_valid        = 1'b0;
        i_coord_x      = '0;
        i_coord_y      = '0;
        i_coord_z      = '0;
        i_last_point   = 1'b0;
        i_ready        = 1'b0;
        error_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        quiet_cycles   = 0;
        bin_width      = prh_pkg::WIDTH_RST;
        clear_cloud_model();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_extremes();
        test_zero_bin_width();
        test_widest_bins();
        test_random_clouds();
        test_result_backpressure();

        i_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
